### hw/rtl/hkd_pkg.sv
// ============================================================================
// hkd_pkg
// Shared constants for the keyboard report new-key detector.
// ============================================================================
package hkd_pkg;

    localparam int CodeWidth   = 8;
    localparam int ReportBytes = 8;
    localparam int SlotBase    = 2;
    localparam int MaxSlots    = 6;
    localparam int ReportWidth = ReportBytes * CodeWidth;

    localparam logic [CodeWidth-1:0] ShiftMask = 8'h22;

    localparam int QueueDepth  = 2;
    localparam int QueuePtrW   = $clog2(QueueDepth);
    localparam int QueueCountW = $clog2(QueueDepth + 1);

endpackage

### hw/rtl/hkd_front.sv
// ============================================================================
// hkd_front
// Accepts reports, checks validity, finds new keys against the stored
// previous keys and updates that store.
// ============================================================================
module hkd_front
    import hkd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ReportWidth-1:0]         s_axis_tdata,
    output logic                           push_valid,
    input  logic                           push_ready,
    output logic [KEY_SLOTS*CodeWidth-1:0] push_keys,
    output logic [KEY_SLOTS-1:0]           push_mask,
    output logic                           push_shift
);

    logic [KEY_SLOTS-1:0][CodeWidth-1:0] prev_reg;
    logic [KEY_SLOTS-1:0][CodeWidth-1:0] prev_next;
    logic [KEY_SLOTS-1:0][CodeWidth-1:0] key;
    logic [KEY_SLOTS-1:0]                new_mask;
    logic                                all_same;
    logic                                accept;

    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            key[i] = s_axis_tdata[(SlotBase + i) * CodeWidth +: CodeWidth];
        end
    end

    always_comb begin
        all_same = 1'b1;
        for (int b = 1; b < ReportBytes; b++) begin
            if (s_axis_tdata[b * CodeWidth +: CodeWidth] != s_axis_tdata[CodeWidth-1:0]) begin
                all_same = 1'b0;
            end
        end
    end

    // allowed marks stored slots at or past the search position
    always_comb begin
        logic [KEY_SLOTS-1:0] allowed;
        logic [KEY_SLOTS-1:0] cand;
        logic [KEY_SLOTS-1:0] smear;
        logic                 active;
        allowed  = '1;
        active   = 1'b1;
        new_mask = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            active = active && (key[i] != '0);
            for (int j = 0; j < KEY_SLOTS; j++) begin
                cand[j] = allowed[j] && (prev_reg[j] == key[i]);
            end
            smear[0] = cand[0];
            for (int j = 1; j < KEY_SLOTS; j++) begin
                smear[j] = smear[j-1] | cand[j];
            end
            if (active) begin
                new_mask[i] = (cand == '0);
                allowed     = smear;
            end
        end
    end

    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_valid    = s_axis_tvalid && !all_same && (new_mask != '0);
    assign push_keys     = key;
    assign push_mask     = new_mask;
    assign push_shift    = (s_axis_tdata[CodeWidth-1:0] & ShiftMask) != '0;
    assign prev_next     = all_same ? '0 : key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (accept) begin
            prev_reg <= prev_next;
        end
    end

endmodule

### hw/rtl/hkd_queue.sv
// ============================================================================
// hkd_queue
// Short register queue between the classifier and the key emitter.
// ============================================================================
module hkd_queue
    import hkd_pkg::*;
#(
    parameter int WIDTH = 55
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]       mem_reg [QueueDepth];
    logic [QueuePtrW-1:0]   wr_ptr_reg;
    logic [QueuePtrW-1:0]   rd_ptr_reg;
    logic [QueueCountW-1:0] count_reg;
    logic [QueueCountW-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = count_reg != QueueCountW'(QueueDepth);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/hkd_back.sv
// ============================================================================
// hkd_back
// Emits the new keys of one queued report, one word per cycle while
// m_axis_tready is high, lowest slot first, marking the final one.
// ============================================================================
module hkd_back
    import hkd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  logic [KEY_SLOTS*CodeWidth-1:0] pop_keys,
    input  logic [KEY_SLOTS-1:0]           pop_mask,
    input  logic                           pop_shift,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [CodeWidth-1:0]           m_axis_tdata,
    output logic                           m_axis_tlast,
    output logic [0:0]                     m_axis_tuser
);

    logic [KEY_SLOTS-1:0][CodeWidth-1:0] keys_reg;
    logic [KEY_SLOTS-1:0]                mask_reg;
    logic                                shift_reg;
    logic                                valid_reg;
    logic [KEY_SLOTS-1:0]                lowest;
    logic [CodeWidth-1:0]                code;
    logic                                last;
    logic                                take;
    logic                                load;

    assign lowest = mask_reg & (~mask_reg + 1'b1);
    assign last   = (mask_reg & ~lowest) == '0;

    always_comb begin
        code = '0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (lowest[j]) begin
                code = code | keys_reg[j];
            end
        end
    end

    assign take      = valid_reg && m_axis_tready;
    assign load      = !valid_reg || (take && last);
    assign pop_ready = load;

    assign m_axis_tvalid   = valid_reg;
    assign m_axis_tdata    = code;
    assign m_axis_tlast    = last;
    assign m_axis_tuser[0] = shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && pop_valid) begin
            keys_reg  <= pop_keys;
            mask_reg  <= pop_mask;
            shift_reg <= pop_shift;
        end else if (take) begin
            mask_reg  <= mask_reg & ~lowest;
        end
    end

endmodule

### hw/rtl/hid_keyboard_new_key_detect.sv
// ============================================================================
// hid_keyboard_new_key_detect
// New-key detection for USB HID boot keyboard reports.
// ============================================================================
// Input stream: one word per 8-byte boot report. An all-equal report clears
// the stored keys and yields nothing. Otherwise each key slot up to the
// first empty one is compared with the previous report's keys, and every
// key not found is sent out on the result stream with the shift flag
// (tuser) and tlast on the final new key of the report.
// Throughput: the front takes one report per cycle while the two-entry
// queue has room; the emitter sends one key word per cycle while m_axis_tready
// is high, so a report with k new keys holds it for k words (up to KEY_SLOTS).
// Order: an accepted report is written into the queue, then loaded into
// the emitter registers when the emitter is free, which show its first key.
// Stall: when m_axis_tready is low the current word holds; reports keep
// entering until the queue is full, then s_axis_tready drops.
// Reset: the stored keys read as zero, the queue empties and no word is
// shown on the result stream.
// ============================================================================
module hid_keyboard_new_key_detect
    import hkd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // modifier_byte, reserved_byte, slot0_code .. slot5_code
    input  logic [ReportWidth-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pressed_code
    output logic [CodeWidth-1:0]   m_axis_tdata,
    output logic                   m_axis_tlast,
    // shift_held
    output logic [0:0]             m_axis_tuser
);

    localparam int KeysW  = KEY_SLOTS * CodeWidth;
    localparam int EntryW = KeysW + KEY_SLOTS + 1;

    logic                 push_valid;
    logic                 push_ready;
    logic [KeysW-1:0]     push_keys;
    logic [KEY_SLOTS-1:0] push_mask;
    logic                 push_shift;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [EntryW-1:0]    pop_data;

    hkd_front #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_keys     (push_keys),
        .push_mask     (push_mask),
        .push_shift    (push_shift)
    );

    hkd_queue #(
        .WIDTH (EntryW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_shift, push_mask, push_keys}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hkd_back #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_keys      (pop_data[KeysW-1:0]),
        .pop_mask      (pop_data[KeysW +: KEY_SLOTS]),
        .pop_shift     (pop_data[EntryW-1]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### hw/rtl/hkd_checker.sv
// ============================================================================
// hkd_checker
// Port-level checks for the new-key detector, bound to the top level.
// ============================================================================
module hkd_checker
    import hkd_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [CodeWidth-1:0]   m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic [0:0]             m_axis_tuser
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("result word or full queue right after reset");

    a_code_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata != '0)
        else $error("empty key code emitted");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

endmodule

bind hid_keyboard_new_key_detect hkd_checker u_hkd_checker (.*);

### dv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the keyboard report new-key detector.
// ============================================================================
// Boot reports go in as words on the input stream and each key word coming
// out is compared with a local model of the detector, which keeps its own
// copy of the previous report's keys. A short table of hand-picked reports
// comes first: invalid all-equal reports, full and empty key sets, reordered
// and repeated keys, and an exhausted search. Random typing sequences follow,
// mixed with invalid reports and raw noise. They run under four idle and
// stall patterns, with one long result-side hold and one drain pause.
// ============================================================================
module tb_top;
    import hkd_pkg::*;

    localparam int KeySlots   = 6;
    localparam int HalfPeriod = 6;
    localparam int RunLimit   = 12 * 300000;
    localparam int PhaseWords = 25;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_KEYS,
        ALL_KEYS
    } check_t;

    typedef struct packed {
        logic [CodeWidth-1:0] pressed_code;
        logic                 shift_held;
        logic                 last_of_report;
    } key_word_t;

    typedef struct {
        logic [ReportWidth-1:0] rpt;
        check_t                 how;
    } report_row_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [ReportWidth-1:0] s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [CodeWidth-1:0]   m_axis_tdata;
    logic                   m_axis_tlast;
    logic [0:0]             m_axis_tuser;

    logic [CodeWidth-1:0] prev_keys [MaxSlots];
    key_word_t            fresh_keys [$];
    key_word_t            pending_keys [$];
    key_word_t            front_key;
    logic [CodeWidth-1:0] held_keys [$];
    report_row_t          directed_rows [$];

    int error_count    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int sink_hold_left = 0;

    hid_keyboard_new_key_detect #(
        .KEY_SLOTS(KeySlots)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always #HalfPeriod aclk = ~aclk;

    task automatic detect_new_keys(input logic [ReportWidth-1:0] rpt);
        logic [CodeWidth-1:0] codes [MaxSlots];
        logic [CodeWidth-1:0] key;
        logic                 all_same;
        logic                 shift;
        logic                 stop;
        int                   pos;
        int                   n;
        fresh_keys.delete();
        all_same = 1'b1;
        for (int i = 1; i < ReportBytes; i++) begin
            if (rpt[i*CodeWidth +: CodeWidth] != rpt[CodeWidth-1:0]) all_same = 1'b0;
        end
        if (all_same) begin
            for (int i = 0; i < MaxSlots; i++) prev_keys[i] = '0;
            return;
        end
        shift = |(rpt[CodeWidth-1:0] & ShiftMask);
        pos   = 0;
        n     = 0;
        stop  = 1'b0;
        for (int i = 0; i < KeySlots && !stop; i++) begin
            key = rpt[(SlotBase+i)*CodeWidth +: CodeWidth];
            if (key == '0) begin
                stop = 1'b1;
            end else begin
                while (pos < KeySlots && prev_keys[pos] != key) pos++;
                if (pos >= KeySlots) begin
                    codes[n] = key;
                    n++;
                end
            end
        end
        for (int i = 0; i < KeySlots; i++) prev_keys[i] = rpt[(SlotBase+i)*CodeWidth +: CodeWidth];
        for (int j = 0; j < n; j++) fresh_keys.push_back({codes[j], shift, 1'(j == n - 1)});
    endtask

    task automatic send_report(input logic [ReportWidth-1:0] rpt, input check_t how);
        logic [CodeWidth-1:0] key;
        logic                 shift;
        int                   n;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rpt;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        detect_new_keys(rpt);
        case (how)
            BY_MODEL: begin
                foreach (fresh_keys[i]) pending_keys.push_back(fresh_keys[i]);
            end
            ALL_KEYS: begin
                shift = |(rpt[CodeWidth-1:0] & ShiftMask);
                n = 0;
                while (n < KeySlots && rpt[(SlotBase+n)*CodeWidth +: CodeWidth] != '0) n++;
                for (int j = 0; j < n; j++) begin
                    key = rpt[(SlotBase+j)*CodeWidth +: CodeWidth];
                    pending_keys.push_back({key, shift, 1'(j == n - 1)});
                end
            end
            default: ;
        endcase
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            @(posedge aclk);
        end
    endtask

    task automatic add_row(input check_t how, input logic [7:0] m, input logic [7:0] r,
                           input logic [7:0] k0, input logic [7:0] k1, input logic [7:0] k2,
                           input logic [7:0] k3, input logic [7:0] k4, input logic [7:0] k5);
        report_row_t row;
        row.rpt = {k5, k4, k3, k2, k1, k0, r, m};
        row.how = how;
        directed_rows.push_back(row);
    endtask

    task automatic type_next_report(output logic [ReportWidth-1:0] rpt);
        logic [CodeWidth-1:0] slots [MaxSlots];
        logic [CodeWidth-1:0] fill;
        logic [CodeWidth-1:0] tmp;
        int                   roll;
        int                   a;
        int                   b;
        roll = $urandom_range(99);
        if (roll < 10) begin
            case ($urandom_range(2))
                0:       fill = 8'h00;
                1:       fill = 8'hFF;
                default: fill = 8'($urandom);
            endcase
            rpt = {ReportBytes{fill}};
            held_keys.delete();
        end else if (roll < 22) begin
            rpt = {$urandom, $urandom};
            if ($urandom_range(1)) begin
                a = SlotBase + $urandom_range(KeySlots - 1);
                rpt[a*CodeWidth +: CodeWidth] = '0;
            end
        end else begin
            if (held_keys.size() == 0 || (held_keys.size() < KeySlots && $urandom_range(1))) begin
                if ($urandom_range(3) == 0) held_keys.push_back(8'($urandom_range(255, 1)));
                else held_keys.push_back(8'($urandom_range(12, 4)));
            end else if ($urandom_range(3) != 0) begin
                held_keys.delete($urandom_range(held_keys.size() - 1));
            end else begin
                a = $urandom_range(held_keys.size() - 1);
                b = $urandom_range(held_keys.size() - 1);
                tmp = held_keys[a];
                held_keys[a] = held_keys[b];
                held_keys[b] = tmp;
            end
            for (int i = 0; i < MaxSlots; i++) begin
                if (i < held_keys.size()) slots[i] = held_keys[i];
                else if ($urandom_range(9) == 0 && i > held_keys.size()) slots[i] = 8'($urandom);
                else slots[i] = '0;
            end
            rpt = {slots[5], slots[4], slots[3], slots[2], slots[1], slots[0],
                   ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00, 8'($urandom)};
        end
    endtask

    always @(posedge aclk) begin
        if (sink_hold_left > 0) begin
            m_axis_tready  <= 1'b0;
            sink_hold_left <= sink_hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_keys.size() == 0) begin
                $error("key word %0h arrived with nothing pending", m_axis_tdata);
                error_count++;
            end else begin
                front_key = pending_keys.pop_front();
                if (m_axis_tdata !== front_key.pressed_code) begin
                    $error("pressed_code: expected %0h, got %0h",
                           front_key.pressed_code, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser[0] !== front_key.shift_held) begin
                    $error("shift_held: expected %0b, got %0b",
                           front_key.shift_held, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tlast !== front_key.last_of_report) begin
                    $error("last_of_report: expected %0b, got %0b",
                           front_key.last_of_report, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #RunLimit;
        $display("[hid_keyboard_new_key_detect] ERROR");
        $finish;
    end

    initial begin
        logic [ReportWidth-1:0] rpt;
        int                     src_pcts [4];
        int                     sink_pcts [4];
        src_pcts  = '{0, 50, 0, 38};
        sink_pcts = '{0, 0, 50, 38};
        for (int i = 0; i < MaxSlots; i++) prev_keys[i] = '0;

        add_row(ALL_KEYS, 8'h02, 8'h00, 8'h04, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00);
        add_row(NO_KEYS,  8'h02, 8'h00, 8'h04, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00);
        add_row(NO_KEYS,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(NO_KEYS,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_row(ALL_KEYS, 8'h20, 8'h00, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA);
        add_row(BY_MODEL, 8'hDD, 8'hFF, 8'hFA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(NO_KEYS,  8'h00, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55);
        add_row(BY_MODEL, 8'h22, 8'h00, 8'h11, 8'h55, 8'h22, 8'h00, 8'h00, 8'h00);
        add_row(BY_MODEL, 8'h01, 8'h00, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07);
        add_row(BY_MODEL, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h08);
        add_row(NO_KEYS,  8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55);
        add_row(ALL_KEYS, 8'h80, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06);
        add_row(BY_MODEL, 8'h00, 8'h00, 8'h06, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05);
        add_row(BY_MODEL, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06);
        add_row(BY_MODEL, 8'h02, 8'h00, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_row(BY_MODEL, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(NO_KEYS,  8'hFF, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ALL_KEYS, 8'hAA, 8'h55, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04);
        add_row(BY_MODEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
        add_row(NO_KEYS,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ALL_KEYS, 8'h7F, 8'h80, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct   = 25;
        sink_stall_pct = 25;
        foreach (directed_rows[i]) send_report(directed_rows[i].rpt, directed_rows[i].how);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = src_pcts[p];
            sink_stall_pct = sink_pcts[p];
            // hold the result side so the queue fills and the input stalls
            if (p == 2) sink_hold_left = 64;
            for (int n = 0; n < PhaseWords; n++) begin
                if (p == 1 && n == PhaseWords / 2) begin
                    s_axis_tvalid <= 1'b0;
                    do @(posedge aclk); while (pending_keys.size() != 0);
                end
                type_next_report(rpt);
                send_report(rpt, BY_MODEL);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_keys.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (error_count == 0) begin
            $display("[hid_keyboard_new_key_detect] OK");
        end else begin
            $display("[hid_keyboard_new_key_detect] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/hkd_pkg.sv
hw/rtl/hkd_front.sv
hw/rtl/hkd_queue.sv
hw/rtl/hkd_back.sv
hw/rtl/hid_keyboard_new_key_detect.sv
hw/rtl/hkd_checker.sv
dv/tb_top.sv
